/* hdl/ple_pkg.sv */
// ple_pkg: shared codes and control bundles for the positional list engine.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ple_pkg;

   // command codes carried on req_command
   localparam logic [2:0] CMD_INS_HEAD = 3'd0;
   localparam logic [2:0] CMD_DEL_HEAD = 3'd1;
   localparam logic [2:0] CMD_INS_TAIL = 3'd2;
   localparam logic [2:0] CMD_DEL_TAIL = 3'd3;
   localparam logic [2:0] CMD_DEL_POS  = 3'd4;
   localparam logic [2:0] CMD_INS_POS  = 3'd5;

   // status codes returned on rsp_status
   localparam logic [1:0] STAT_DONE    = 2'd0;
   localparam logic [1:0] STAT_EMPTY   = 2'd1;
   localparam logic [1:0] STAT_INVALID = 2'd2;
   localparam logic [1:0] STAT_FULL    = 2'd3;

   // controller states, one-hot
   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_RUN  = 3'b010,
      S_DONE = 3'b100
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;    // latch the request word and its decode
      logic step;    // one shift step: issue a read, retire the previous one
      logic finish;  // final write (inserts only), count update, result capture
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic reject;  // request fails its checks, no list change
      logic drained; // all reads issued and retired
   } dp_stat_type;

endpackage

/* hdl/ple_ctrl.sv */
// ple_ctrl: sequencing state machine of the positional list engine.
// Depends on ple_pkg for the state type and the command/status bundles.
`timescale 1ns / 1ps

module ple_ctrl
   import ple_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   output logic        rsp_strobe,
   output ctl_cmd_type ctl_cmd,
   input  dp_stat_type dp_stat
);

   state_type state_ff, state_in;

   // next state and datapath commands
   always_comb begin
      state_in       = state_ff;
      ctl_cmd.load   = 1'b0;
      ctl_cmd.step   = 1'b0;
      ctl_cmd.finish = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               ctl_cmd.load = 1'b1;
               state_in     = dp_stat.reject ? S_DONE : S_RUN;
            end
         end
         S_RUN: begin
            if (dp_stat.drained) begin
               ctl_cmd.finish = 1'b1;
               state_in       = S_DONE;
            end else begin
               ctl_cmd.step = 1'b1;
            end
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = (state_ff == S_DONE);

endmodule

/* hdl/ple_datapath.sv */
// ple_datapath: element memory, count, request decode and the shift engine.
// Depends on ple_pkg; driven by ple_ctrl through ctl_cmd_type.
`timescale 1ns / 1ps

module ple_datapath
   import ple_pkg::*;
#(
   parameter int CAPACITY = 16
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic [2:0]         req_command,
   input  logic signed [31:0] req_value,
   input  logic [7:0]         req_position,
   input  ctl_cmd_type        ctl_cmd,
   output dp_stat_type        dp_stat,
   output logic signed [31:0] rsp_removed_value,
   output logic [1:0]         rsp_status
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = ((CW > 8) ? CW : 8) + 1;

   // element memory, one read and one write port
   logic [31:0] mem [CAPACITY];

   logic [CW-1:0]     count_ff;
   logic              rv_ff;       // read data valid in rd_data_ff
   logic              ins_ff;
   logic              first_ff;    // next retired read is the removed word
   logic [AW-1:0]     idx_ff;
   logic [31:0]       value_ff;
   logic [CW-1:0]     left_ff;     // reads still to issue
   logic [AW-1:0]     rd_ptr_ff;
   logic [AW-1:0]     rv_addr_ff;
   logic [31:0]       rd_data_ff;
   logic [31:0]       got_ff;
   logic [31:0]       removed_ff;
   logic [1:0]        status_ff;

   // request decode
   logic              dec_reject;
   logic              dec_ins;
   logic [1:0]        dec_err;
   logic [AW-1:0]     dec_idx;
   logic [CW-1:0]     dec_left;
   logic [AW-1:0]     dec_rd_ptr;
   logic              full;
   logic              empty;
   logic [PW-1:0]     pos_x;
   logic [PW-1:0]     cnt_x;
   logic [PW-1:0]     pos_m1;

   assign full   = (count_ff == CW'(CAPACITY));
   assign empty  = (count_ff == '0);
   assign pos_x  = PW'(req_position);
   assign cnt_x  = PW'(count_ff);
   assign pos_m1 = pos_x - PW'(1);

   always_comb begin
      dec_reject = 1'b0;
      dec_ins    = 1'b0;
      dec_err    = STAT_INVALID;
      dec_idx    = '0;
      case (req_command)
         CMD_INS_HEAD: begin
            dec_ins = 1'b1;
            if (full) begin
               dec_reject = 1'b1;
               dec_err    = STAT_FULL;
            end
         end
         CMD_DEL_HEAD: begin
            if (empty) begin
               dec_reject = 1'b1;
               dec_err    = STAT_EMPTY;
            end
         end
         CMD_INS_TAIL: begin
            dec_ins = 1'b1;
            dec_idx = AW'(count_ff);
            if (full) begin
               dec_reject = 1'b1;
               dec_err    = STAT_FULL;
            end
         end
         CMD_DEL_TAIL: begin
            dec_idx = AW'(count_ff - CW'(1));
            if (empty) begin
               dec_reject = 1'b1;
               dec_err    = STAT_EMPTY;
            end
         end
         CMD_DEL_POS: begin
            dec_idx = AW'(pos_m1);
            if (empty) begin
               dec_reject = 1'b1;
               dec_err    = STAT_EMPTY;
            end else if (pos_x == '0 || pos_x > cnt_x) begin
               dec_reject = 1'b1;
               dec_err    = STAT_INVALID;
            end
         end
         CMD_INS_POS: begin
            dec_ins = 1'b1;
            dec_idx = AW'(pos_m1);
            if (pos_x == '0 || pos_x > cnt_x + PW'(1)) begin
               dec_reject = 1'b1;
               dec_err    = STAT_INVALID;
            end else if (full) begin
               dec_reject = 1'b1;
               dec_err    = STAT_FULL;
            end
         end
         default: begin
            dec_reject = 1'b1;
            dec_err    = STAT_INVALID;
         end
      endcase
   end

   // inserts walk down from the tail, deletes walk up from idx
   assign dec_left   = count_ff - CW'(dec_idx);
   assign dec_rd_ptr = dec_ins ? AW'(count_ff - CW'(1)) : dec_idx;

   // memory port control
   logic          rd_en;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [31:0]   wr_data;

   assign rd_en = ctl_cmd.step && (left_ff != '0);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = ins_ff ? (rv_addr_ff + AW'(1)) : (rv_addr_ff - AW'(1));
      wr_data = rd_data_ff;
      if (ctl_cmd.finish) begin
         wr_en   = ins_ff;
         wr_addr = idx_ff;
         wr_data = value_ff;
      end else if (ctl_cmd.step && rv_ff && (ins_ff || !first_ff)) begin
         wr_en = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_ptr_ff];
      end
   end

   // control state: count and read-valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rv_ff    <= 1'b0;
      end else begin
         if (ctl_cmd.load) begin
            rv_ff <= 1'b0;
         end else if (ctl_cmd.step) begin
            rv_ff <= rd_en;
         end
         if (ctl_cmd.finish) begin
            count_ff <= ins_ff ? (count_ff + CW'(1)) : (count_ff - CW'(1));
         end
      end
   end

   // operation registers and result word
   always_ff @(posedge clock) begin
      if (ctl_cmd.load) begin
         ins_ff     <= dec_ins;
         idx_ff     <= dec_idx;
         value_ff   <= req_value;
         left_ff    <= dec_left;
         rd_ptr_ff  <= dec_rd_ptr;
         first_ff   <= 1'b1;
         status_ff  <= dec_err;
         removed_ff <= '0;
      end
      if (ctl_cmd.step) begin
         if (rd_en) begin
            rv_addr_ff <= rd_ptr_ff;
            rd_ptr_ff  <= ins_ff ? (rd_ptr_ff - AW'(1)) : (rd_ptr_ff + AW'(1));
            left_ff    <= left_ff - CW'(1);
         end
         if (rv_ff && !ins_ff && first_ff) begin
            got_ff   <= rd_data_ff;
            first_ff <= 1'b0;
         end
      end
      if (ctl_cmd.finish) begin
         status_ff  <= STAT_DONE;
         removed_ff <= ins_ff ? 32'd0 : got_ff;
      end
   end

   assign dp_stat.reject  = dec_reject;
   assign dp_stat.drained = (left_ff == '0) && !rv_ff;

   assign rsp_removed_value = $signed(removed_ff);
   assign rsp_status        = status_ff;

endmodule

/* hdl/positional_list_engine.sv */
// positional_list_engine: top level, ordered list of signed 32-bit words.
// Depends on ple_pkg, ple_ctrl and ple_datapath.
//
//   channel   | ports                                        | handshake
//   ----------+----------------------------------------------+---------------------
//   request   | req_command, req_value, req_position         | start & !busy
//   response  | rsp_removed_value, rsp_status                | rsp_strobe, 1 cycle
//
// A request that moves n words (n = count - target slot, at most CAPACITY)
// is loaded, shifts word by word, then finishes with the count update and the
// insert's final write and responds; a rejected request goes straight to the
// response. The element memory has one read and one write port: while the
// list shifts, one word is read and one written per cycle, save the removed
// word of a delete. Reset clears the count; the memory needs no clearing pass.
// The receiver cannot stall: rsp_strobe flags the response for one cycle only.
`timescale 1ns / 1ps

module positional_list_engine
   import ple_pkg::*;
#(
   parameter int CAPACITY = 16
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_command,
   input  logic signed [31:0] req_value,
   input  logic [7:0]         req_position,
   output logic               rsp_strobe,
   output logic signed [31:0] rsp_removed_value,
   output logic [1:0]         rsp_status
);

   ctl_cmd_type ctl_cmd;
   dp_stat_type dp_stat;

   ple_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .ctl_cmd    (ctl_cmd),
      .dp_stat    (dp_stat)
   );

   ple_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_command       (req_command),
      .req_value         (req_value),
      .req_position      (req_position),
      .ctl_cmd           (ctl_cmd),
      .dp_stat           (dp_stat),
      .rsp_removed_value (rsp_removed_value),
      .rsp_status        (rsp_status)
   );

endmodule

/* hdl/ple_checker.sv */
// ple_checker: port-level properties of the positional list engine, bound to the top.
// Depends on ple_pkg for status codes.
`timescale 1ns / 1ps

module ple_checker
   import ple_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_strobe,
   input logic signed [31:0] rsp_removed_value,
   input logic [1:0]         rsp_status
);

   // an accepted word makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted request did not raise busy");

   // a response only appears while an item is in flight
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("response strobe while idle");

   // exactly one response per item: the block is free right after it
   a_strobe_then_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !busy && !rsp_strobe)
      else $error("block not idle after response");

   // failed operations return a zero word
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status != STAT_DONE |-> rsp_removed_value == 32'sd0)
      else $error("nonzero word on failed operation");

endmodule

bind positional_list_engine ple_checker u_ple_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_strobe        (rsp_strobe),
   .rsp_removed_value (rsp_removed_value),
   .rsp_status        (rsp_status)
);
